[rtl/rrtt_pkg.sv]
// ----------------------------------------------------------------------------
// rrtt_pkg: shared types and constants of the round-robin task table.
// Holds the slot count, command and status codes, slot states, controller states and the
// controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package rrtt_pkg;

  localparam int unsigned SlotCount = 16;
  localparam int unsigned SlotW = $clog2(SlotCount);

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_KILL   = 3'd1,
    OP_QUERY  = 3'd2,
    OP_YIELD  = 3'd3,
    OP_SLEEP  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SL_DEAD    = 2'd0,
    SL_READY   = 2'd1,
    SL_RUNNING = 2'd2,
    SL_WAITING = 2'd3
  } slot_state_t;

  typedef enum logic [2:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_SCAN,
    FSM_APPLY,
    FSM_READ,
    FSM_OUT
  } fsm_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_step;   // clear one slot during the init sweep
    logic load;        // capture the request and start a scan
    logic step;        // examine the slot under the scan pointer
    logic apply;       // perform the update of the matched slot
    logic read;        // register the reported slot's fields
    logic fail;        // report a failure status
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_done;
    logic hit;         // the examined slot matches
    logic scan_last;   // the examined slot is the last of the scan
    logic direct;      // the request needs no scan (sleep, unknown)
    logic direct_ok;   // a direct request succeeds
  } dp_stat_t;

endpackage

[rtl/rrtt_if.sv]
// ----------------------------------------------------------------------------
// rrtt_in_if / rrtt_out_if: request and result channels.
// Valid/ready channels with a source and a sink modport.
// ----------------------------------------------------------------------------
interface rrtt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] target_id;
  logic [31:0] new_priority;
  logic [31:0] sleep_ticks;
  logic [31:0] now_ticks;
  modport source (output valid, operation, target_id, new_priority, sleep_ticks,
                  now_ticks, input ready);
  modport sink (input valid, operation, target_id, new_priority, sleep_ticks,
                now_ticks, output ready);
endinterface

interface rrtt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_id;
  logic [3:0]  result_slot;
  logic [1:0]  result_state;
  logic [31:0] result_priority;
  logic [31:0] result_wake;
  modport source (output valid, status, result_id, result_slot, result_state,
                  result_priority, result_wake, input ready);
  modport sink (input valid, status, result_id, result_slot, result_state,
                result_priority, result_wake, output ready);
endinterface

[rtl/rrtt_ctrl.sv]
// ----------------------------------------------------------------------------
// rrtt_ctrl: controller of the task table.
// Sequences the init sweep, the slot scan, the update, the read and the result.
// ----------------------------------------------------------------------------
module rrtt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rrtt_pkg::dp_stat_t stat,
  output rrtt_pkg::dp_cmd_t  cmd
);

  rrtt_pkg::fsm_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rrtt_pkg::FSM_INIT;
    else        state_r <= state_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrtt_pkg::FSM_INIT:  if (stat.init_done) state_nxt = rrtt_pkg::FSM_IDLE;
      rrtt_pkg::FSM_IDLE:  if (in_valid) state_nxt = rrtt_pkg::FSM_SCAN;
      rrtt_pkg::FSM_SCAN: begin
        if (stat.direct) state_nxt = stat.direct_ok ? rrtt_pkg::FSM_APPLY
                                                    : rrtt_pkg::FSM_OUT;
        else if (stat.hit) state_nxt = rrtt_pkg::FSM_APPLY;
        else if (stat.scan_last) state_nxt = rrtt_pkg::FSM_OUT;
      end
      rrtt_pkg::FSM_APPLY: state_nxt = rrtt_pkg::FSM_READ;
      rrtt_pkg::FSM_READ:  state_nxt = rrtt_pkg::FSM_OUT;
      rrtt_pkg::FSM_OUT:   if (out_ready) state_nxt = rrtt_pkg::FSM_IDLE;
      default:             state_nxt = rrtt_pkg::FSM_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      rrtt_pkg::FSM_INIT:  cmd.init_step = 1'b1;
      rrtt_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rrtt_pkg::FSM_SCAN: begin
        cmd.step = !stat.direct;
        cmd.fail = stat.direct ? !stat.direct_ok : (!stat.hit && stat.scan_last);
      end
      rrtt_pkg::FSM_APPLY: cmd.apply = 1'b1;
      rrtt_pkg::FSM_READ:  cmd.read = 1'b1;
      rrtt_pkg::FSM_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

[rtl/rrtt_datapath.sv]
// ----------------------------------------------------------------------------
// rrtt_datapath: slot storage, scan pointer and result register.
// Slot fields live in memories; slot states live in flip-flops.
// ----------------------------------------------------------------------------
module rrtt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  rrtt_pkg::dp_cmd_t  cmd,
  output rrtt_pkg::dp_stat_t stat,
  input  logic [2:0]         in_operation,
  input  logic [31:0]        in_target_id,
  input  logic [31:0]        in_new_priority,
  input  logic [31:0]        in_sleep_ticks,
  input  logic [31:0]        in_now_ticks,
  output logic [1:0]         out_status,
  output logic [31:0]        out_result_id,
  output logic [3:0]         out_result_slot,
  output logic [1:0]         out_result_state,
  output logic [31:0]        out_result_priority,
  output logic [31:0]        out_result_wake
);

  localparam int unsigned N = rrtt_pkg::SlotCount;
  localparam int unsigned W = rrtt_pkg::SlotW;
  localparam logic [W-1:0] LastSlot = W'(N - 1);

  // Slot states are read and written at the selected slot (sel_r).
  rrtt_pkg::slot_state_t sstate_r [N];
  logic [31:0] id_mem   [N];
  logic [31:0] prio_mem [N];
  logic [31:0] wake_mem [N];

  logic [2:0]  op_r;
  logic [31:0] tid_r, prio_r, ticks_r, now_r, idc_r;
  logic [W-1:0] ptr_r, cur_r, cnt_r, sel_r;
  logic [31:0] rd_id_r, rd_wake_r;
  logic [1:0]  status_r;
  logic [31:0] res_id_r, res_prio_r, res_wake_r;
  logic [3:0]  res_slot_r;
  logic [1:0]  res_state_r;
  logic [W-1:0] next_ptr;
  logic        ptr_wrap;

  // Registered reads of id and wake at the scan pointer.
  always_ff @(posedge clk) begin
    rd_id_r   <= id_mem[ptr_r];
    rd_wake_r <= wake_mem[ptr_r];
  end

  assign ptr_wrap = (ptr_r == LastSlot);
  assign next_ptr = ptr_wrap ? '0 : ptr_r + 1'b1;

  // Match decision on the slot read in the previous cycle (index sel_r).
  rrtt_pkg::slot_state_t st_sel;
  logic hit;
  assign st_sel = sstate_r[sel_r];
  always_comb begin
    hit = 1'b0;
    case (op_r)
      rrtt_pkg::OP_CREATE: hit = (st_sel == rrtt_pkg::SL_DEAD);
      rrtt_pkg::OP_KILL:   hit = (rd_id_r == tid_r);
      rrtt_pkg::OP_QUERY:  hit = (rd_id_r == tid_r) && (st_sel != rrtt_pkg::SL_DEAD);
      rrtt_pkg::OP_YIELD:  hit = (st_sel == rrtt_pkg::SL_READY) ||
                                 ((st_sel == rrtt_pkg::SL_WAITING) && (now_r >= rd_wake_r));
      default:             hit = 1'b0;
    endcase
  end

  // A scan starts with a priming read: phase_r marks that rd_* hold sel_r's data.
  logic phase_r;
  logic [W-1:0] scan_len;
  assign scan_len = (op_r == rrtt_pkg::OP_CREATE) ? W'(N - 2) : LastSlot;

  assign stat.hit       = phase_r && hit;
  assign stat.scan_last = phase_r && (cnt_r == scan_len);
  assign stat.direct    = !(op_r == rrtt_pkg::OP_CREATE || op_r == rrtt_pkg::OP_KILL ||
                            op_r == rrtt_pkg::OP_QUERY || op_r == rrtt_pkg::OP_YIELD);
  assign stat.direct_ok = (op_r == rrtt_pkg::OP_SLEEP) && (cur_r != '0);
  assign stat.init_done = ptr_wrap;

  // Control and scan registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      cur_r   <= '0;
      idc_r   <= 32'd1;
      phase_r <= 1'b0;
      cnt_r   <= '0;
      for (int i = 0; i < N; i++) sstate_r[i] <= rrtt_pkg::SL_DEAD;
      sstate_r[0] <= rrtt_pkg::SL_RUNNING;
    end else begin
      if (cmd.init_step) ptr_r <= next_ptr;
      if (cmd.load) begin
        op_r    <= in_operation;
        tid_r   <= in_target_id;
        prio_r  <= in_new_priority;
        ticks_r <= in_sleep_ticks;
        now_r   <= in_now_ticks;
        phase_r <= 1'b0;
        cnt_r   <= '0;
        if (in_operation == rrtt_pkg::OP_CREATE)     ptr_r <= W'(1);
        else if (in_operation == rrtt_pkg::OP_YIELD) ptr_r <= (cur_r == LastSlot) ? '0
                                                             : cur_r + 1'b1;
        else if (in_operation == rrtt_pkg::OP_SLEEP) ptr_r <= cur_r;
        else                                         ptr_r <= '0;
      end
      // The matched slot stays selected; otherwise the scan moves on.
      if (cmd.step) begin
        phase_r <= 1'b1;
        ptr_r   <= next_ptr;
        if (!stat.hit) sel_r <= ptr_r;
        if (phase_r) cnt_r <= cnt_r + 1'b1;
      end
      if (stat.direct && cmd.load == 1'b0 && !cmd.step && !cmd.apply && !cmd.read)
        sel_r <= cur_r;
      if (cmd.apply) begin
        ptr_r <= sel_r;
        case (op_r)
          rrtt_pkg::OP_CREATE: begin
            sstate_r[sel_r] <= rrtt_pkg::SL_READY;
            idc_r <= idc_r + 32'd1;
          end
          rrtt_pkg::OP_KILL: if (sel_r != '0) sstate_r[sel_r] <= rrtt_pkg::SL_DEAD;
          rrtt_pkg::OP_YIELD: begin
            sstate_r[sel_r] <= rrtt_pkg::SL_READY;
            cur_r <= sel_r;
          end
          rrtt_pkg::OP_SLEEP: sstate_r[sel_r] <= rrtt_pkg::SL_WAITING;
          default: ;
        endcase
      end
    end
  end

  // Memory writes for the init sweep and the applied update.
  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      id_mem[ptr_r]   <= '0;
      prio_mem[ptr_r] <= '0;
      wake_mem[ptr_r] <= '0;
    end else if (cmd.apply) begin
      case (op_r)
        rrtt_pkg::OP_CREATE: begin
          id_mem[sel_r]   <= idc_r;
          prio_mem[sel_r] <= prio_r;
          wake_mem[sel_r] <= '0;
        end
        rrtt_pkg::OP_YIELD: if (sstate_r[sel_r] == rrtt_pkg::SL_WAITING)
          wake_mem[sel_r] <= '0;
        rrtt_pkg::OP_SLEEP: wake_mem[sel_r] <= now_r + ticks_r;
        default: ;
      endcase
    end
  end

  // Result register: read captures the reported slot as updated by apply,
  // fail clears the fields.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      status_r    <= rrtt_pkg::ST_OK;
      res_id_r    <= id_mem[sel_r];
      res_slot_r  <= 4'(sel_r);
      res_state_r <= sstate_r[sel_r];
      res_prio_r  <= prio_mem[sel_r];
      res_wake_r  <= wake_mem[sel_r];
    end else if (cmd.fail) begin
      status_r    <= (op_r == rrtt_pkg::OP_CREATE) ? rrtt_pkg::ST_FULL
                                                   : rrtt_pkg::ST_NOTFOUND;
      res_id_r    <= '0;
      res_slot_r  <= '0;
      res_state_r <= '0;
      res_prio_r  <= '0;
      res_wake_r  <= '0;
    end
  end

  assign out_status          = status_r;
  assign out_result_id       = res_id_r;
  assign out_result_slot     = res_slot_r;
  assign out_result_state    = res_state_r;
  assign out_result_priority = res_prio_r;
  assign out_result_wake     = res_wake_r;

endmodule

[rtl/round_robin_task_table.sv]
// ----------------------------------------------------------------------------
// round_robin_task_table: task slot table with round-robin yield.
//
//   channel | direction | carries
//   in      | sink      | operation, target_id, new_priority, sleep/now ticks
//   out     | source    | status, result id/slot/state/priority/wake
//
// One request at a time: a scan examines one slot per cycle, and the next
// request waits until out.ready takes the result.
// After reset an init sweep clears the slot memories, during which no
// request is taken. A stalled result holds the block.
// ----------------------------------------------------------------------------
module round_robin_task_table (
  input logic clk,
  input logic rst_n,
  rrtt_in_if.sink    in_ch,
  rrtt_out_if.source out_ch
);

  rrtt_pkg::dp_cmd_t  cmd;
  rrtt_pkg::dp_stat_t stat;

  rrtt_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  rrtt_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_operation       (in_ch.operation),
    .in_target_id       (in_ch.target_id),
    .in_new_priority    (in_ch.new_priority),
    .in_sleep_ticks     (in_ch.sleep_ticks),
    .in_now_ticks       (in_ch.now_ticks),
    .out_status         (out_ch.status),
    .out_result_id      (out_ch.result_id),
    .out_result_slot    (out_ch.result_slot),
    .out_result_state   (out_ch.result_state),
    .out_result_priority(out_ch.result_priority),
    .out_result_wake    (out_ch.result_wake)
  );

endmodule

[rtl/rrtt_checker.sv]
// ----------------------------------------------------------------------------
// rrtt_checker: port-level checks of the task table.
// Watches the request and result handshakes over time.
// ----------------------------------------------------------------------------
module rrtt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status
);

  // One request at a time: no request is taken while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // A result stays until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // Status is one of the defined codes.
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");

  // An accepted request closes the request side after its handshake.
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second request taken");

endmodule

bind round_robin_task_table rrtt_checker u_rrtt_checker (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status)
);
